// File: hdl/lcgi_pkg.sv
// ----------------------------------------------------------------------------
// lcgi_pkg
// Shared widths and types for the line color gradient interpolator.
// ----------------------------------------------------------------------------
package lcgi_pkg;

  // Coordinate width in bits. The offset and numerator widths follow from it.
  localparam int unsigned CW = 16;

  // Width of a color channel and of a packed RGB888 color.
  localparam int unsigned CHW = 8;
  localparam int unsigned COLW = 3 * CHW;

  // The signed offsets place and dist.
  localparam int unsigned OFW = CW + 1;

  // The signed numerator, and its magnitude.
  localparam int unsigned NSW = CW + 11;
  localparam int unsigned NUW = CW + 10;

  // Number of division stages. Each stage resolves two quotient bits.
  localparam int unsigned DIV_STAGES = CHW / 2;

  // Pipeline depth: decode, multiply, saturation check, then the divider.
  localparam int unsigned NSTAGE = 3 + DIV_STAGES;

  // One color channel on its way through the divider.
  typedef struct packed {
    logic            clr;  // quotient is negative, so the channel clamps to zero
    logic            sat;  // quotient is above the channel range
    logic [NUW-1:0]  rem;  // partial remainder
    logic [CHW-1:0]  q;    // quotient bits resolved so far
  } chan_div_t;

  // Everything an item carries through the divider stages.
  typedef struct packed {
    logic            byp;      // result is a fixed color
    logic [COLW-1:0] byp_col;  // that fixed color
    logic [CW-1:0]   dabs;     // magnitude of the distance
    chan_div_t [2:0] ch;       // red, green, blue
  } div_item_t;

endpackage

// File: hdl/line_color_gradient_interp_top.sv
// ----------------------------------------------------------------------------
// line_color_gradient_interp_top
// Blends an RGB888 color between a line's start and end colors per pixel.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output is not stalled, and
// returns one color per pixel, in order. The pipeline has a decode stage, a
// multiply stage, a saturation check, and a four-stage restoring divider
// that resolves two quotient bits per stage. Each stage holds its item
// while the stage ahead of it is full and stalled, so bubbles are squeezed
// out and back-to-back throughput is one pixel per clock while the output
// is not stalled.
module line_color_gradient_interp_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lcgi_pkg::COLW-1:0]   in_color_start,
  input  logic [lcgi_pkg::COLW-1:0]   in_color_end,
  input  logic signed [lcgi_pkg::CW-1:0] in_pos_x,
  input  logic signed [lcgi_pkg::CW-1:0] in_pos_y,
  input  logic signed [lcgi_pkg::CW-1:0] in_line_start_x,
  input  logic signed [lcgi_pkg::CW-1:0] in_line_start_y,
  input  logic signed [lcgi_pkg::CW-1:0] in_line_end_x,
  input  logic signed [lcgi_pkg::CW-1:0] in_line_end_y,
  input  logic signed [lcgi_pkg::CW-1:0] in_span_x,
  input  logic signed [lcgi_pkg::CW-1:0] in_span_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lcgi_pkg::COLW-1:0]   out_pixel_color
);
  import lcgi_pkg::*;

  // Stage valid bits and per-stage ready.
  logic [NSTAGE-1:0] v_r, v_nxt;
  logic [NSTAGE-1:0] rdy;

  // Decode stage registers.
  logic                   a_byp_r;
  logic [COLW-1:0]        a_byp_col_r;
  logic [COLW-1:0]        a_c0_r, a_c1_r;
  logic signed [OFW-1:0]  a_place_r, a_dist_r;

  // Multiply stage registers.
  logic                   b_byp_r;
  logic [COLW-1:0]        b_byp_col_r;
  logic [CW-1:0]          b_dabs_r;
  logic [2:0]             b_neg_r;
  logic [NUW-1:0]         b_nabs_r [3];

  // Saturation stage and divider stage registers.
  div_item_t              c_r;
  div_item_t              d_r [DIV_STAGES];

  // Stage handshake: a stage takes a new item when it is empty or moving on.
  always_comb begin
    rdy[NSTAGE-1] = !v_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Decode: pick the major axis, form place and dist, flag fixed colors.
  logic signed [OFW-1:0] place_nxt, dist_nxt;
  logic                  byp_nxt;
  logic [COLW-1:0]       byp_col_nxt;

  always_comb begin
    if (in_span_x > in_span_y) begin
      place_nxt = OFW'(in_pos_x) - OFW'(in_line_start_x);
      dist_nxt  = OFW'(in_line_end_x) - OFW'(in_line_start_x);
    end else begin
      place_nxt = OFW'(in_pos_y) - OFW'(in_line_start_y);
      dist_nxt  = OFW'(in_line_end_y) - OFW'(in_line_start_y);
    end
    byp_nxt     = 1'b0;
    byp_col_nxt = in_color_end;
    if (in_color_start == in_color_end) begin
      byp_nxt     = 1'b1;
      byp_col_nxt = in_color_start;
    end else if (dist_nxt == '0) begin
      byp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_byp_r     <= byp_nxt;
      a_byp_col_r <= byp_col_nxt;
      a_c0_r      <= in_color_start;
      a_c1_r      <= in_color_end;
      a_place_r   <= place_nxt;
      a_dist_r    <= dist_nxt;
    end
  end

  // Multiply: numerator c0*(dist-place) + c1*place per channel, then the
  // sign of the quotient and the magnitudes of numerator and divisor.
  logic signed [OFW:0]    rest;
  logic signed [NSW-1:0]  num [3];
  logic [2:0]             neg_nxt;
  logic [NUW-1:0]         nabs_nxt [3];
  logic [CW-1:0]          dabs_nxt;

  always_comb begin
    rest = (OFW+1)'(a_dist_r) - (OFW+1)'(a_place_r);
    for (int c = 0; c < 3; c++) begin
      num[c] = NSW'($signed({1'b0, a_c0_r[c*CHW +: CHW]}) * rest)
             + NSW'($signed({1'b0, a_c1_r[c*CHW +: CHW]}) * a_place_r);
      neg_nxt[c]  = num[c][NSW-1] ^ a_dist_r[OFW-1];
      nabs_nxt[c] = num[c][NSW-1] ? NUW'(-num[c]) : NUW'(num[c]);
    end
    dabs_nxt = a_dist_r[OFW-1] ? CW'(-a_dist_r) : CW'(a_dist_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b_byp_r     <= a_byp_r;
      b_byp_col_r <= a_byp_col_r;
      b_dabs_r    <= dabs_nxt;
      b_neg_r     <= neg_nxt;
      for (int c = 0; c < 3; c++) begin
        b_nabs_r[c] <= nabs_nxt[c];
      end
    end
  end

  // Saturation check: a quotient of 256 or more clamps to full scale.
  div_item_t c_nxt;

  always_comb begin
    c_nxt.byp     = b_byp_r;
    c_nxt.byp_col = b_byp_col_r;
    c_nxt.dabs    = b_dabs_r;
    for (int c = 0; c < 3; c++) begin
      c_nxt.ch[c].clr = b_neg_r[c];
      c_nxt.ch[c].sat = b_nabs_r[c] >= NUW'({b_dabs_r, {CHW{1'b0}}});
      c_nxt.ch[c].rem = b_nabs_r[c];
      c_nxt.ch[c].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      c_r <= c_nxt;
    end
  end

  // Divider: each stage subtracts the shifted divisor for two quotient bits.
  div_item_t d_nxt [DIV_STAGES];

  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      d_nxt[s] = (s == 0) ? c_r : d_r[(s == 0) ? 0 : s - 1];
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 2; j++) begin
          if (d_nxt[s].ch[c].rem >=
              (NUW'(d_nxt[s].dabs) << (CHW - 1 - 2 * s - j))) begin
            d_nxt[s].ch[c].rem = d_nxt[s].ch[c].rem -
                                 (NUW'(d_nxt[s].dabs) << (CHW - 1 - 2 * s - j));
            d_nxt[s].ch[c].q[CHW - 1 - 2 * s - j] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rdy[3 + s]) begin
        d_r[s] <= d_nxt[s];
      end
    end
  end

  // Output: fixed color, or per channel zero, full scale or the quotient.
  always_comb begin
    out_pixel_color = d_r[DIV_STAGES-1].byp_col;
    if (!d_r[DIV_STAGES-1].byp) begin
      for (int c = 0; c < 3; c++) begin
        priority if (d_r[DIV_STAGES-1].ch[c].clr) begin
          out_pixel_color[c*CHW +: CHW] = '0;
        end else if (d_r[DIV_STAGES-1].ch[c].sat) begin
          out_pixel_color[c*CHW +: CHW] = '1;
        end else begin
          out_pixel_color[c*CHW +: CHW] = d_r[DIV_STAGES-1].ch[c].q;
        end
      end
    end
  end

  assign out_valid = v_r[NSTAGE-1];

`ifndef SYNTHESIS
  // An unstalled output means every stage can move.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A stage only fills from the stage behind it.
  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[1]) |-> $past(v_r[0]))
    else $error("multiply stage filled without a decoded item");

  // A stalled output item does not vanish.
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result lost");
`endif

endmodule

// File: sim/line_color_gradient_interp_top_test.sv
// ----------------------------------------------------------------------------
// line_color_gradient_interp_top_test
// Checks the per-pixel color blend against an in-bench prediction.
// ----------------------------------------------------------------------------
// Directed pixels cover equal colors, zero distance, both axes, extrapolation
// with clamping and coordinate extremes. Random pixels follow, mostly drawn
// on lines with the pixel near the segment, under several idling phases.
module line_color_gradient_interp_top_test;
  import lcgi_pkg::*;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [COLW-1:0] color_t;

  // One pixel transaction, with an optional fixed expected color.
  typedef struct {
    color_t c0;
    color_t c1;
    coord_t px, py, sx, sy, ex, ey, dx, dy;
    bit     has_exp;
    color_t exp_col;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  color_t in_color_start = '0;
  color_t in_color_end = '0;
  coord_t in_pos_x = '0, in_pos_y = '0;
  coord_t in_line_start_x = '0, in_line_start_y = '0;
  coord_t in_line_end_x = '0, in_line_end_y = '0;
  coord_t in_span_x = '0, in_span_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  color_t out_pixel_color;

  color_t pending_colors[$];
  int     mismatches = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  line_color_gradient_interp_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Blend one channel with truncation toward zero, then clamp.
  function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
                                            input longint place, input longint len);
    longint num;
    longint q;
    num = longint'(a) * (len - place) + longint'(b) * place;
    q = num / len;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic color_t gradient_color(input pixel_t p);
    longint place;
    longint len;
    if (p.c0 == p.c1) return p.c0;
    if (p.dx > p.dy) begin
      place = longint'(p.px) - longint'(p.sx);
      len = longint'(p.ex) - longint'(p.sx);
    end else begin
      place = longint'(p.py) - longint'(p.sy);
      len = longint'(p.ey) - longint'(p.sy);
    end
    if (len == 0) return p.c1;
    return {blend_chan(p.c0[23:16], p.c1[23:16], place, len),
            blend_chan(p.c0[15:8], p.c1[15:8], place, len),
            blend_chan(p.c0[7:0], p.c1[7:0], place, len)};
  endfunction

  // Hand one pixel to the block and record what it should return.
  // Valid stays high between back-to-back transactions and drops only
  // while the sender idles.
  task automatic send_pixel(input pixel_t p);
    while (($urandom % 100) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_color_start <= p.c0;
    in_color_end <= p.c1;
    in_pos_x <= p.px;
    in_pos_y <= p.py;
    in_line_start_x <= p.sx;
    in_line_start_y <= p.sy;
    in_line_end_x <= p.ex;
    in_line_end_y <= p.ey;
    in_span_x <= p.dx;
    in_span_y <= p.dy;
    pending_colors.push_back(p.has_exp ? p.exp_col : gradient_color(p));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic pixel_t mk(input color_t c0, input color_t c1,
                                input coord_t px, input coord_t py,
                                input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey,
                                input coord_t dx, input coord_t dy,
                                input bit has_exp = 0, input color_t e = '0);
    pixel_t p;
    p = '{c0, c1, px, py, sx, sy, ex, ey, dx, dy, has_exp, e};
    return p;
  endfunction

  // Random pixel: mostly on a real line near the segment, else raw noise.
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int sel;
    sel = $urandom_range(0, 99);
    p.c0 = color_t'($urandom);
    p.c1 = (sel < 5) ? p.c0 : color_t'($urandom);
    p.has_exp = 0;
    p.exp_col = '0;
    if (sel < 75) begin
      p.sx = coord_t'($urandom_range(0, 400) - 200);
      p.sy = coord_t'($urandom_range(0, 400) - 200);
      p.ex = coord_t'(p.sx + $urandom_range(0, 300) - 150);
      p.ey = coord_t'(p.sy + $urandom_range(0, 300) - 150);
      p.dx = (p.ex > p.sx) ? p.ex - p.sx : p.sx - p.ex;
      p.dy = (p.ey > p.sy) ? p.ey - p.sy : p.sy - p.ey;
      p.px = coord_t'(p.sx + $urandom_range(0, 360) - 30);
      p.py = coord_t'(p.sy + $urandom_range(0, 360) - 30);
      if (p.ex < p.sx) p.px = p.sx - (p.px - p.sx);
      if (p.ey < p.sy) p.py = p.sy - (p.py - p.sy);
    end else begin
      p.px = coord_t'($urandom); p.py = coord_t'($urandom);
      p.sx = coord_t'($urandom); p.sy = coord_t'($urandom);
      p.ex = coord_t'($urandom); p.ey = coord_t'($urandom);
      p.dx = coord_t'($urandom); p.dy = coord_t'($urandom);
    end
    return p;
  endfunction

  // Accept results with random stalls and compare with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_colors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected color %h", out_pixel_color);
        end else begin
          if (out_pixel_color !== pending_colors[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Color mismatch: expected %h, got %h",
                       pending_colors[0], out_pixel_color);
          end
          void'(pending_colors.pop_front());
        end
      end
      out_ready <= (($urandom % 100) >= recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    pixel_t directed[$];
    int wait_cycles;
    directed.push_back(mk(24'h123456, 24'h123456, 5, 5, 0, 0, 10, 10, 1, 0, 1, 24'h123456));
    directed.push_back(mk(24'hFF0000, 24'h00FF00, 7, 3, 4, 0, 4, 9, 5, 2, 1, 24'h00FF00));
    directed.push_back(mk(24'hFF0000, 24'h00FF00, 3, 7, 0, 7, 9, 7, 2, 5, 1, 24'h00FF00));
    directed.push_back(mk(24'h000000, 24'hFFFFFF, 0, 0, 0, 0, 10, 0, 10, 0, 1, 24'h000000));
    directed.push_back(mk(24'h000000, 24'hFFFFFF, 10, 0, 0, 0, 10, 0, 10, 0, 1, 24'hFFFFFF));
    directed.push_back(mk(24'h000000, 24'hFFFFFF, 20, 0, 0, 0, 10, 0, 10, 0, 1, 24'hFFFFFF));
    directed.push_back(mk(24'h000000, 24'hFFFFFF, -5, 0, 0, 0, 10, 0, 10, 0, 1, 24'h000000));
    directed.push_back(mk(24'hFFFFFF, 24'h000000, 0, -5, 0, 0, 0, 10, 0, 10, 1, 24'hFFFFFF));
    directed.push_back(mk(24'hFF8000, 24'h00FF80, 5, 0, 0, 0, 10, 0, 10, 10));
    directed.push_back(mk(24'hFF8000, 24'h00FF80, 0, 3, 0, 0, 0, 7, 10, 10));
    directed.push_back(mk(24'h010203, 24'hFEFDFC, 3, 0, 0, 0, 7, 0, 7, -3));
    directed.push_back(mk(24'hABCDEF, 24'h102030, -3, 0, 0, 0, -7, 0, 7, 0));
    directed.push_back(mk(24'h00FF00, 24'hFF00FF, 32767, 0, -32768, 0, 32767, 0, 32767, -32768));
    directed.push_back(mk(24'h00FF00, 24'hFF00FF, -32768, 0, 32767, 0, -32768, 0, 32767, -32768));
    directed.push_back(mk(24'hFFFFFF, 24'h000001, 0, 32767, 0, -32768, 0, 32767, -32768, 32767));
    directed.push_back(mk(24'h000000, 24'hFFFFFF, 32767, -32768, -32768, 32767, 1, 0,
                          -32768, -32768));
    directed.push_back(mk(24'h808080, 24'h7F7F7F, 1, 1, 0, 0, 3, 3, 32767, 32767));
    directed.push_back(mk(24'hFFFFFF, 24'hFFFFFE, -1, -1, 1, 1, -1, -1, 0, 0, 1, 24'hFFFFFE));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_pixel(directed[i]);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 70; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 70; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      repeat (250) send_pixel(rand_pixel());
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    wait_cycles = 0;
    while (pending_colors.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
